/* src/probed_hash_id_table_top_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the probed hash id table.
// ---------------------------------------------------------------------------
`ifndef PROBED_HASH_ID_TABLE_TOP_DEFINES_SVH
`define PROBED_HASH_ID_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PHT_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define PHT_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/pht_pkg.sv */
// ---------------------------------------------------------------------------
// pht_pkg
// Constants, codes and controller/datapath interface types of the hash table.
// ---------------------------------------------------------------------------
package pht_pkg;

  localparam int TABLE_SLOTS   = 1024;
  localparam int SLOT_BITS     = $clog2(TABLE_SLOTS);
  localparam int RECORD_BITS   = 20;
  localparam int KEY_BITS      = 64;
  localparam int COUNT_BITS    = 11;
  localparam int RETIRED_BITS  = 20;
  localparam int ENTRY_BITS    = KEY_BITS + RECORD_BITS;
  localparam int OUT_DATA_BITS = 64;
  localparam int OUT_PAD_BITS  = OUT_DATA_BITS - RECORD_BITS - 2 * COUNT_BITS - RETIRED_BITS;
  localparam int FILL_LIMIT    = (TABLE_SLOTS * 7 + 9) / 10 - 1;

  localparam logic [KEY_BITS-1:0] KEY_EMPTY = '0;
  localparam logic [KEY_BITS-1:0] KEY_TOMB  = '1;
  localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_PRESENT   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    HOP_NONE,
    HOP_PRE,
    HOP_MUL_LL,
    HOP_MUL_HL,
    HOP_MUL_LH,
    HOP_MIX
  } hash_op_t;

  typedef struct packed {
    logic     in_ready;
    logic     capture;
    hash_op_t hop;
    logic     round;
    logic     probe_rd;
    logic     probe_chk;
    logic     clr_wr;
    logic     apply;
    logic     out_load;
  } pht_cmd_t;

  typedef struct packed {
    logic reserved;
    logic is_clear;
    logic probe_stop;
    logic sweep_last;
    logic out_free;
  } pht_sts_t;

endpackage

/* src/pht_ram.sv */
// ---------------------------------------------------------------------------
// pht_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module pht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/pht_ctrl.sv */
// ---------------------------------------------------------------------------
// pht_ctrl
// Request sequencer: clear sweep, hash rounds, probe loop, apply and output.
// ---------------------------------------------------------------------------
module pht_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  pht_pkg::pht_sts_t sts,
  output pht_pkg::pht_cmd_t cmd
);
  import pht_pkg::*;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_PRE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_MIX,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_CLEAR,
    S_APPLY,
    S_FINISH
  } state_t;

  state_t state;
  logic   round;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      round <= 1'b0;
    end else begin
      case (state)
        S_INIT: begin
          if (sts.sweep_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) state <= S_DECODE;
        end
        S_DECODE: begin
          round <= 1'b0;
          if (sts.is_clear) begin
            state <= S_CLEAR;
          end else if (sts.reserved) begin
            state <= S_APPLY;
          end else begin
            state <= S_PRE;
          end
        end
        S_PRE:  state <= S_MUL0;
        S_MUL0: state <= S_MUL1;
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_MIX;
        S_MIX: begin
          if (round) begin
            state <= S_PROBE_RD;
          end else begin
            round <= 1'b1;
            state <= S_MUL0;
          end
        end
        S_PROBE_RD: state <= S_PROBE_CHK;
        S_PROBE_CHK: begin
          state <= sts.probe_stop ? S_APPLY : S_PROBE_RD;
        end
        S_CLEAR: begin
          if (sts.sweep_last) state <= S_APPLY;
        end
        S_APPLY: state <= S_FINISH;
        S_FINISH: begin
          if (sts.out_free) state <= S_IDLE;
        end
        default: state <= S_INIT;
      endcase
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.hop   = HOP_NONE;
    cmd.round = round;
    case (state)
      S_INIT, S_CLEAR: cmd.clr_wr = 1'b1;
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.capture  = in_valid;
      end
      S_PRE:       cmd.hop       = HOP_PRE;
      S_MUL0:      cmd.hop       = HOP_MUL_LL;
      S_MUL1:      cmd.hop       = HOP_MUL_HL;
      S_MUL2:      cmd.hop       = HOP_MUL_LH;
      S_MIX:       cmd.hop       = HOP_MIX;
      S_PROBE_RD:  cmd.probe_rd  = 1'b1;
      S_PROBE_CHK: cmd.probe_chk = 1'b1;
      S_APPLY:     cmd.apply     = 1'b1;
      S_FINISH:    cmd.out_load  = sts.out_free;
      default: ;
    endcase
  end

endmodule

/* src/pht_dp.sv */
// ---------------------------------------------------------------------------
// pht_dp
// Datapath: key hash, slot RAM, probe tracking, counters and result register.
// ---------------------------------------------------------------------------
`include "probed_hash_id_table_top_defines.svh"

module pht_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  pht_pkg::pht_cmd_t                  cmd,
  output pht_pkg::pht_sts_t                  sts,
  input  logic [pht_pkg::KEY_BITS-1:0]       key_in,
  input  logic [1:0]                         req_in,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [pht_pkg::OUT_DATA_BITS-1:0]  out_data,
  output logic [2:0]                         out_status
);
  import pht_pkg::*;

  logic [KEY_BITS-1:0]     key_q;
  req_t                    req_q;
  logic [63:0]             hv;
  logic [63:0]             acc;
  logic [SLOT_BITS-1:0]    pos;
  logic [SLOT_BITS-1:0]    stop_pos;
  logic [SLOT_BITS-1:0]    probe_cnt;
  logic [SLOT_BITS-1:0]    tomb_pos;
  logic                    tomb_valid;
  logic                    empty_seen;
  logic                    hit;
  logic [RECORD_BITS-1:0]  hit_rec;
  logic [SLOT_BITS-1:0]    sweep_addr;

  logic [COUNT_BITS-1:0]   live;
  logic [COUNT_BITS-1:0]   tomb;
  logic [COUNT_BITS-1:0]   peak;
  logic [RETIRED_BITS-1:0] retired;
  logic [RECORD_BITS-1:0]  next_rec;
  logic [COUNT_BITS-1:0]   live_next;
  logic [COUNT_BITS-1:0]   tomb_next;
  logic [COUNT_BITS-1:0]   peak_next;
  logic [RETIRED_BITS-1:0] retired_next;
  logic [RECORD_BITS-1:0]  next_rec_next;

  status_t                 res_status;
  logic [RECORD_BITS-1:0]  res_rec;
  status_t                 ap_status;
  logic [RECORD_BITS-1:0]  ap_rec;
  logic                    ap_we;
  logic [SLOT_BITS-1:0]    ap_addr;
  logic [ENTRY_BITS-1:0]   ap_wdata;

  logic                    ram_we;
  logic [SLOT_BITS-1:0]    ram_waddr;
  logic [ENTRY_BITS-1:0]   ram_wdata;
  logic [ENTRY_BITS-1:0]   ram_rdata;

  logic [KEY_BITS-1:0]     held_key;
  logic [RECORD_BITS-1:0]  held_rec;
  logic                    slot_hit;
  logic                    slot_empty;
  logic                    slot_tomb;
  logic                    key_reserved;
  logic                    free_valid;
  logic [SLOT_BITS-1:0]    free_pos;
  logic [COUNT_BITS:0]     fill_sum;

  logic [63:0]             c_sel;
  logic [31:0]             mul_a;
  logic [31:0]             mul_b;
  logic [63:0]             prod;
  logic [63:0]             mix_val;

  pht_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (TABLE_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.probe_rd),
    .raddr (pos),
    .rdata (ram_rdata)
  );

  assign held_key     = ram_rdata[KEY_BITS-1:0];
  assign held_rec     = ram_rdata[ENTRY_BITS-1:KEY_BITS];
  assign slot_hit     = held_key == key_q;
  assign slot_empty   = held_key == KEY_EMPTY;
  assign slot_tomb    = held_key == KEY_TOMB;
  assign key_reserved = (key_q == KEY_EMPTY) || (key_q == KEY_TOMB);
  assign free_valid   = empty_seen || tomb_valid;
  assign free_pos     = tomb_valid ? tomb_pos : stop_pos;
  assign fill_sum     = {1'b0, live} + {1'b0, tomb};

  assign sts.reserved   = key_reserved;
  assign sts.is_clear   = req_q == REQ_CLEAR;
  assign sts.probe_stop = slot_hit || slot_empty || (probe_cnt == SLOT_BITS'(TABLE_SLOTS - 1));
  assign sts.sweep_last = sweep_addr == SLOT_BITS'(TABLE_SLOTS - 1);
  assign sts.out_free   = !out_valid || out_ready;

  // 64x64 low product from three 32x32 partial products
  assign c_sel   = cmd.round ? MIX_C2 : MIX_C1;
  assign mul_a   = (cmd.hop == HOP_MUL_HL) ? hv[63:32] : hv[31:0];
  assign mul_b   = (cmd.hop == HOP_MUL_LH) ? c_sel[63:32] : c_sel[31:0];
  assign prod    = 64'(mul_a) * 64'(mul_b);
  assign mix_val = cmd.round ? (acc ^ (acc >> 31)) : (acc ^ (acc >> 27));

  assign ram_we    = cmd.clr_wr || (cmd.apply && ap_we);
  assign ram_waddr = cmd.clr_wr ? sweep_addr : ap_addr;
  assign ram_wdata = cmd.clr_wr ? '0 : ap_wdata;

  always_comb begin
    ap_status     = ST_OK;
    ap_rec        = '0;
    ap_we         = 1'b0;
    ap_addr       = stop_pos;
    ap_wdata      = '0;
    live_next     = live;
    tomb_next     = tomb;
    peak_next     = peak;
    retired_next  = retired;
    next_rec_next = next_rec;
    if (req_q == REQ_CLEAR) begin
      live_next     = '0;
      tomb_next     = '0;
      peak_next     = '0;
      retired_next  = '0;
      next_rec_next = RECORD_BITS'(1);
    end else if (key_reserved) begin
      ap_status = ST_INVALID;
    end else begin
      case (req_q)
        REQ_INSERT: begin
          if (hit) begin
            ap_status = ST_PRESENT;
            ap_rec    = hit_rec;
          end else if (fill_sum >= (COUNT_BITS + 1)'(FILL_LIMIT) ||
                       next_rec == '0 || !free_valid) begin
            ap_status = ST_FULL;
          end else begin
            ap_we         = 1'b1;
            ap_addr       = free_pos;
            ap_wdata      = {next_rec, key_q};
            ap_rec        = next_rec;
            next_rec_next = next_rec + 1'b1;
            live_next     = live + 1'b1;
            if (tomb_valid && tomb != '0) tomb_next = tomb - 1'b1;
            if (live_next > peak) peak_next = live_next;
          end
        end
        REQ_REMOVE: begin
          if (!hit) begin
            ap_status = ST_NOT_FOUND;
          end else begin
            ap_we     = 1'b1;
            ap_wdata  = {{RECORD_BITS{1'b0}}, KEY_TOMB};
            ap_rec    = hit_rec;
            tomb_next = tomb + 1'b1;
            if (live != '0) live_next = live - 1'b1;
            if (retired != '1) retired_next = retired + 1'b1;
          end
        end
        REQ_LOOKUP: begin
          if (hit) begin
            ap_rec = hit_rec;
          end else begin
            ap_status = ST_NOT_FOUND;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live       <= '0;
      tomb       <= '0;
      peak       <= '0;
      retired    <= '0;
      next_rec   <= RECORD_BITS'(1);
      sweep_addr <= '0;
      out_valid  <= 1'b0;
      tomb_valid <= 1'b0;
      empty_seen <= 1'b0;
      hit        <= 1'b0;
      probe_cnt  <= '0;
    end else begin
      if (cmd.clr_wr) sweep_addr <= sweep_addr + 1'b1;
      if (cmd.hop == HOP_MIX && cmd.round) begin
        tomb_valid <= 1'b0;
        empty_seen <= 1'b0;
        hit        <= 1'b0;
        probe_cnt  <= '0;
      end
      if (cmd.probe_chk) begin
        hit       <= slot_hit;
        probe_cnt <= probe_cnt + 1'b1;
        if (slot_empty) empty_seen <= 1'b1;
        if (slot_tomb && !tomb_valid) tomb_valid <= 1'b1;
      end
      if (cmd.apply) begin
        live     <= live_next;
        tomb     <= tomb_next;
        peak     <= peak_next;
        retired  <= retired_next;
        next_rec <= next_rec_next;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      key_q <= key_in;
      req_q <= req_t'(req_in);
    end
    case (cmd.hop)
      HOP_PRE:    hv  <= key_q ^ (key_q >> 30);
      HOP_MUL_LL: acc <= prod;
      HOP_MUL_HL: acc <= acc + {prod[31:0], 32'h0};
      HOP_MUL_LH: acc <= acc + {prod[31:0], 32'h0};
      HOP_MIX: begin
        hv <= mix_val;
        if (cmd.round) pos <= mix_val[SLOT_BITS-1:0];
      end
      default: ;
    endcase
    if (cmd.probe_chk) begin
      stop_pos <= pos;
      hit_rec  <= held_rec;
      pos      <= pos + 1'b1;
      if (slot_tomb && !tomb_valid) tomb_pos <= pos;
    end
    if (cmd.apply) begin
      res_status <= ap_status;
      res_rec    <= ap_rec;
    end
    if (cmd.out_load) begin
      out_data   <= {{OUT_PAD_BITS{1'b0}}, retired, peak, live, res_rec};
      out_status <= res_status;
    end
  end

  `PHT_ASSERT_NOW(a_fill_bound, clk, rst, 1'b1, fill_sum <= (COUNT_BITS + 1)'(FILL_LIMIT), "fill bound exceeded")
  `PHT_ASSERT_NOW(a_peak_covers_live, clk, rst, 1'b1, peak >= live, "peak below live count")
  `PHT_ASSERT_NOW(a_no_write_on_probe, clk, rst, cmd.probe_rd, !ram_we, "slot write during probe read")
  `PHT_ASSERT_NEXT(a_result_after_load, clk, rst, cmd.out_load, out_valid, "result not presented")

endmodule

/* src/probed_hash_id_table_top.sv */
// ---------------------------------------------------------------------------
// probed_hash_id_table_top
// Open-addressing id table with linear probing and sequential record numbers.
// ---------------------------------------------------------------------------
// One request is worked at a time. The splitmix64 hash of the key runs on one
// shared 32x32 multiplier, and the probes follow it, one slot after another:
// each probe is a read of the slot RAM followed by a check of its data. A
// reserved key skips the hash and the probes. A clear request, and reset,
// sweep the slot RAM one slot a cycle over all 1024 slots; no request is
// accepted during the sweep after reset. The result register lets the next
// request be accepted while the previous result waits on m_axis_tready.
module probed_hash_id_table_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // key[63:0]
  input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // record_number[19:0], live_entries[30:20],
                                     // peak_entries[41:31], retired_entries[61:42]
  output logic [2:0]  m_axis_tuser   // status[2:0]
);
  import pht_pkg::*;

  pht_cmd_t cmd;
  pht_sts_t sts;

  pht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .sts      (sts),
    .cmd      (cmd)
  );

  pht_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .key_in     (s_axis_tdata),
    .req_in     (s_axis_tuser),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_data   (m_axis_tdata),
    .out_status (m_axis_tuser)
  );

  assign s_axis_tready = cmd.in_ready;

endmodule

/* test/probed_hash_id_table_top_tb.sv */
// ---------------------------------------------------------------------------
// probed_hash_id_table_top_tb
// Self-checking bench for the probed hash id table. A shadow copy of the slot
// store predicts every reply. Stimulus opens with a short table of requests:
// reserved keys, duplicates, removal and tombstone reuse, and clear. Random
// traffic follows over a small key pool that includes keys whose home slots
// sit at the top of the table, so their probes wrap. Then the table is filled
// to the occupancy limit and worked while full. Both stream sides stall at
// random, except for one stretch of steady flow.
// ---------------------------------------------------------------------------
module probed_hash_id_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pht_pkg::*;

  typedef struct packed {
    status_t                 status;
    logic [RECORD_BITS-1:0]  record;
    logic [COUNT_BITS-1:0]   live;
    logic [COUNT_BITS-1:0]   peak;
    logic [RETIRED_BITS-1:0] retired;
  } table_reply_t;

  typedef struct packed {
    req_t         req;
    logic [63:0]  key;
    logic         pinned;
    table_reply_t reply;
  } table_row_t;

  localparam table_reply_t MISSING_REPLY = '{ST_NOT_FOUND, '0, '0, '0, '0};
  localparam table_reply_t INVALID_REPLY = '{ST_INVALID, '0, '0, '0, '0};

  localparam table_row_t DIRECTED_ROWS [23] = '{
    '{REQ_LOOKUP, 64'h0000_0000_0000_0001, 1'b1, MISSING_REPLY},
    '{REQ_REMOVE, 64'h8000_0000_0000_0000, 1'b1, MISSING_REPLY},
    '{REQ_INSERT, KEY_EMPTY,               1'b1, INVALID_REPLY},
    '{REQ_INSERT, KEY_TOMB,                1'b1, INVALID_REPLY},
    '{REQ_REMOVE, KEY_TOMB,                1'b1, INVALID_REPLY},
    '{REQ_LOOKUP, KEY_EMPTY,               1'b1, INVALID_REPLY},
    '{REQ_INSERT, 64'h0000_0000_0000_0001, 1'b1, '{ST_OK, 20'd1, 11'd1, 11'd1, 20'd0}},
    '{REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1, '{ST_OK, 20'd2, 11'd2, 11'd2, 20'd0}},
    '{REQ_INSERT, 64'h0000_0000_0000_0001, 1'b1, '{ST_PRESENT, 20'd1, 11'd2, 11'd2, 20'd0}},
    '{REQ_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, '0},
    '{REQ_INSERT, 64'h8000_0000_0000_0000, 1'b0, '0},
    '{REQ_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, '0},
    '{REQ_REMOVE, 64'h0000_0000_0000_0001, 1'b0, '0},
    '{REQ_LOOKUP, 64'h0000_0000_0000_0001, 1'b0, '0},
    '{REQ_REMOVE, 64'h0000_0000_0000_0001, 1'b0, '0},
    '{REQ_INSERT, 64'h0000_0000_0000_0001, 1'b0, '0},
    '{REQ_INSERT, 64'h5555_5555_5555_5555, 1'b0, '0},
    '{REQ_REMOVE, 64'h8000_0000_0000_0000, 1'b0, '0},
    '{REQ_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
    '{REQ_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, '0},
    '{REQ_CLEAR,  64'hAAAA_AAAA_AAAA_AAAA, 1'b1, '0},
    '{REQ_LOOKUP, 64'h0000_0000_0000_0001, 1'b1, MISSING_REPLY},
    '{REQ_INSERT, 64'h0000_0000_0000_0001, 1'b1, '{ST_OK, 20'd1, 11'd1, 11'd1, 20'd0}}
  };

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  bit           steady = 1'b0;
  int unsigned  mismatches = 0;
  table_reply_t awaited_replies [$];
  table_reply_t last_outcome;

  logic [63:0]            shadow_key    [TABLE_SLOTS];
  logic [RECORD_BITS-1:0] shadow_record [TABLE_SLOTS];
  int unsigned            shadow_live;
  int unsigned            shadow_tombs;
  int unsigned            shadow_next;
  int unsigned            shadow_peak;
  int unsigned            shadow_retired;
  logic [63:0]            key_pool [32];
  logic [63:0]            fill_keys [$];

  probed_hash_id_table_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #120_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [63:0] splitmix_finalize(logic [63:0] v);
    v ^= v >> 30;
    v *= MIX_C1;
    v ^= v >> 27;
    v *= MIX_C2;
    v ^= v >> 31;
    return v;
  endfunction

  function automatic int unsigned home_slot(logic [63:0] key);
    logic [63:0] h;
    h = splitmix_finalize(key);
    return 32'(h[SLOT_BITS-1:0]);
  endfunction

  function automatic void clear_shadow();
    foreach (shadow_key[i]) begin
      shadow_key[i]    = KEY_EMPTY;
      shadow_record[i] = '0;
    end
    shadow_live    = 0;
    shadow_tombs   = 0;
    shadow_next    = 1;
    shadow_peak    = 0;
    shadow_retired = 0;
  endfunction

  function automatic table_reply_t table_request_outcome(req_t req, logic [63:0] key);
    table_reply_t r;
    int unsigned  pos, tomb, hit, free_slot;
    bit           found, have_free, have_tomb;
    r.status  = ST_OK;
    r.record  = '0;
    found     = 1'b0;
    have_free = 1'b0;
    have_tomb = 1'b0;
    tomb      = 0;
    hit       = 0;
    free_slot = 0;
    if (req == REQ_CLEAR) begin
      clear_shadow();
    end else if (key == KEY_EMPTY || key == KEY_TOMB) begin
      r.status = ST_INVALID;
    end else begin
      pos = home_slot(key);
      for (int n = 0; n < TABLE_SLOTS && !found && !have_free; n++) begin
        if (shadow_key[pos] == KEY_EMPTY) begin
          have_free = 1'b1;
          free_slot = have_tomb ? tomb : pos;
        end else if (shadow_key[pos] == key) begin
          found = 1'b1;
          hit   = pos;
        end else begin
          if (shadow_key[pos] == KEY_TOMB && !have_tomb) begin
            have_tomb = 1'b1;
            tomb      = pos;
          end
          pos = (pos + 1) % TABLE_SLOTS;
        end
      end
      if (!found && !have_free && have_tomb) begin
        have_free = 1'b1;
        free_slot = tomb;
      end
      case (req)
        REQ_INSERT: begin
          if (found) begin
            r.status = ST_PRESENT;
            r.record = shadow_record[hit];
          end else if ((shadow_live + shadow_tombs + 1) * 10 >= TABLE_SLOTS * 7 ||
                       shadow_next == 0 || !have_free) begin
            r.status = ST_FULL;
          end else begin
            if (shadow_key[free_slot] == KEY_TOMB && shadow_tombs > 0) shadow_tombs--;
            shadow_key[free_slot]    = key;
            shadow_record[free_slot] = RECORD_BITS'(shadow_next);
            r.record                 = RECORD_BITS'(shadow_next);
            shadow_next              = (shadow_next + 1) & ((1 << RECORD_BITS) - 1);
            shadow_live++;
            if (shadow_live > shadow_peak) shadow_peak = shadow_live;
          end
        end
        REQ_REMOVE: begin
          if (!found) begin
            r.status = ST_NOT_FOUND;
          end else begin
            r.record           = shadow_record[hit];
            shadow_key[hit]    = KEY_TOMB;
            shadow_record[hit] = '0;
            if (shadow_live > 0) shadow_live--;
            shadow_tombs++;
            if (shadow_retired < (1 << RETIRED_BITS) - 1) shadow_retired++;
          end
        end
        default: begin
          if (!found) r.status = ST_NOT_FOUND;
          else r.record = shadow_record[hit];
        end
      endcase
    end
    r.live    = COUNT_BITS'(shadow_live);
    r.peak    = COUNT_BITS'(shadow_peak);
    r.retired = RETIRED_BITS'(shadow_retired);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < 100)
      $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic issue_request(input req_t req, input logic [63:0] key, input logic pinned,
                               input table_reply_t pinned_reply);
    int unsigned gap;
    if (!steady && $urandom_range(99) < 33) begin
      gap = $urandom_range(1, 20);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= key;
    do @(posedge clk); while (!s_axis_tready);
    last_outcome = table_request_outcome(req, key);
    awaited_replies.push_back(pinned ? pinned_reply : last_outcome);
  endtask

  task automatic send_request(input req_t req, input logic [63:0] key);
    issue_request(req, key, 1'b0, '0);
  endtask

  task automatic pool_traffic(input int unsigned count);
    logic [63:0] k;
    int unsigned pick;
    // twelve of the 32 keys have home slots at the top of the table or at slot 0, so probes wrap
    foreach (key_pool[i]) begin
      if (i < 12) begin
        do k = {$urandom, $urandom};
        while (home_slot(k) > 0 && home_slot(k) < TABLE_SLOTS - 3);
      end else begin
        k = {$urandom, $urandom};
      end
      key_pool[i] = k;
    end
    repeat (count) begin
      pick = $urandom_range(99);
      k    = key_pool[$urandom_range(31)];
      if (pick < 3)
        send_request(REQ_CLEAR, {$urandom, $urandom});
      else if (pick < 8)
        send_request(req_t'($urandom_range(2)), $urandom_range(1) ? KEY_TOMB : KEY_EMPTY);
      else if (pick < 45)
        send_request(REQ_INSERT, k);
      else if (pick < 65)
        send_request(REQ_REMOVE, k);
      else if (pick < 85)
        send_request(REQ_LOOKUP, k);
      else
        send_request(req_t'($urandom_range(2)), {$urandom, $urandom});
    end
  endtask

  always @(posedge clk) begin
    m_axis_tready <= rst ? 1'b0 : (steady || $urandom_range(99) >= 33);
  end

  always @(posedge clk) begin
    table_reply_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (awaited_replies.size() == 0) begin
        report_mismatch("unexpected reply", m_axis_tdata, '0);
      end else begin
        want = awaited_replies.pop_front();
        if (m_axis_tuser != want.status)
          report_mismatch("status", 64'(m_axis_tuser), 64'(want.status));
        if (m_axis_tdata[19:0] != want.record)
          report_mismatch("record_number", 64'(m_axis_tdata[19:0]), 64'(want.record));
        if (m_axis_tdata[30:20] != want.live)
          report_mismatch("live_entries", 64'(m_axis_tdata[30:20]), 64'(want.live));
        if (m_axis_tdata[41:31] != want.peak)
          report_mismatch("peak_entries", 64'(m_axis_tdata[41:31]), 64'(want.peak));
        if (m_axis_tdata[61:42] != want.retired)
          report_mismatch("retired_entries", 64'(m_axis_tdata[61:42]), 64'(want.retired));
      end
    end
  end

  initial begin
    logic [63:0] k;
    int unsigned filled;
    clear_shadow();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < $size(DIRECTED_ROWS); i++)
      issue_request(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].key, DIRECTED_ROWS[i].pinned,
                    DIRECTED_ROWS[i].reply);

    pool_traffic(300);

    // fill to the occupancy limit, with steady flow over the middle stretch
    send_request(REQ_CLEAR, {$urandom, $urandom});
    filled = 0;
    while (last_outcome.status != ST_FULL) begin
      steady = (filled >= 200 && filled < 500);
      k = {$urandom, $urandom};
      fill_keys.push_back(k);
      send_request(REQ_INSERT, k);
      filled++;
    end
    steady = 1'b0;

    repeat (40) begin
      k = fill_keys[$urandom_range(fill_keys.size() - 1)];
      case ($urandom_range(3))
        0:       send_request(REQ_REMOVE, k);
        1:       send_request(REQ_INSERT, k);
        2:       send_request(REQ_LOOKUP, k);
        default: send_request(REQ_INSERT, {$urandom, $urandom});
      endcase
    end

    send_request(REQ_CLEAR, {$urandom, $urandom});
    pool_traffic(220);
    s_axis_tvalid <= 1'b0;

    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
